FILE: rtl/core/clipped_color_key_blitter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clipped color key blitter
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_COLOR_KEY_BLITTER_ASSERT_SVH
`define CLIPPED_COLOR_KEY_BLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCKB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCKB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cckb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped color key blitter package
// Frame geometry, field widths, command codes and shared helper functions.
// ----------------------------------------------------------------------------
package cckb_pkg;

   localparam int SCREEN_WIDTH  = 96;
   localparam int SCREEN_HEIGHT = 64;
   localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int COL_W         = $clog2(SCREEN_WIDTH);
   localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

   localparam int PIXEL_W  = 16;
   localparam int NARROW_W = 8;
   localparam int POS_W    = 10;
   localparam int SPAN_W   = 8;
   localparam int KEY_W    = 17;
   // One extra bit holds origin plus scan offset without overflow.
   localparam int COORD_W  = POS_W + 1;

   localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE_DEPTH - 1);

   typedef enum logic [1:0] {
      CMD_FILL  = 2'd0,
      CMD_START = 2'd1,
      CMD_PIXEL = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic start;
      logic step;
   } scan_ctrl_type;

   typedef struct packed {
      logic                      active;
      logic                      last;
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      logic [KEY_W-1:0]          key;
   } scan_stat_type;

   function automatic logic on_screen(input logic signed [COORD_W-1:0] col,
                                      input logic signed [COORD_W-1:0] row);
      logic col_ok;
      logic row_ok;
      col_ok = !col[COORD_W-1] && (col < $signed(COORD_W'(SCREEN_WIDTH)));
      row_ok = !row[COORD_W-1] && (row < $signed(COORD_W'(SCREEN_HEIGHT)));
      return col_ok && row_ok;
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(
      input logic signed [COORD_W-1:0] col,
      input logic signed [COORD_W-1:0] row);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(SCREEN_WIDTH);
      return base + ADDR_W'(col[COL_W-1:0]);
   endfunction

   function automatic logic signed [COORD_W-1:0] widen_pos(
      input logic signed [POS_W-1:0] pos);
      return {{(COORD_W-POS_W){pos[POS_W-1]}}, pos};
   endfunction

endpackage

FILE: rtl/core/cckb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cckb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cckb_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite scan unit
// Holds the sprite origin, size and key, and walks the row-major scan position.
// ----------------------------------------------------------------------------
module cckb_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  cckb_pkg::scan_ctrl_type           ctrl,
   input  logic signed [cckb_pkg::POS_W-1:0] pos_x,
   input  logic signed [cckb_pkg::POS_W-1:0] pos_y,
   input  logic [cckb_pkg::SPAN_W-1:0]       span_w,
   input  logic [cckb_pkg::SPAN_W-1:0]       span_h,
   input  logic [cckb_pkg::KEY_W-1:0]        key,
   output cckb_pkg::scan_stat_type           stat
);

   logic signed [cckb_pkg::POS_W-1:0] origin_col_ff, origin_row_ff;
   logic [cckb_pkg::SPAN_W-1:0]       span_cols_ff, span_rows_ff;
   logic [cckb_pkg::SPAN_W-1:0]       scan_col_ff, scan_row_ff;
   logic [cckb_pkg::KEY_W-1:0]        key_ff;
   logic                              active_ff;

   logic [cckb_pkg::SPAN_W:0] col_next, row_next;
   logic                      col_last, row_last;

   assign col_next = {1'b0, scan_col_ff} + 1'b1;
   assign row_next = {1'b0, scan_row_ff} + 1'b1;
   assign col_last = col_next >= {1'b0, span_cols_ff};
   assign row_last = row_next >= {1'b0, span_rows_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff <= '0;
         origin_row_ff <= '0;
         span_cols_ff  <= '0;
         span_rows_ff  <= '0;
         scan_col_ff   <= '0;
         scan_row_ff   <= '0;
         key_ff        <= '1;
         active_ff     <= 1'b0;
      end else if (ctrl.start) begin
         origin_col_ff <= pos_x;
         origin_row_ff <= pos_y;
         span_cols_ff  <= span_w;
         span_rows_ff  <= span_h;
         key_ff        <= key;
         scan_col_ff   <= '0;
         scan_row_ff   <= '0;
         active_ff     <= (span_w != '0) && (span_h != '0);
      end else if (ctrl.step && active_ff) begin
         // Off-screen and keyed pixels advance the scan just like stored ones.
         if (col_last) begin
            scan_col_ff <= '0;
            if (row_last) begin
               scan_row_ff <= '0;
               active_ff   <= 1'b0;
            end else begin
               scan_row_ff <= row_next[cckb_pkg::SPAN_W-1:0];
            end
         end else begin
            scan_col_ff <= col_next[cckb_pkg::SPAN_W-1:0];
         end
      end
   end

   always_comb begin
      stat.active = active_ff;
      stat.last   = col_last && row_last;
      stat.col    = cckb_pkg::widen_pos(origin_col_ff)
                    + $signed({{(cckb_pkg::COORD_W-cckb_pkg::SPAN_W){1'b0}}, scan_col_ff});
      stat.row    = cckb_pkg::widen_pos(origin_row_ff)
                    + $signed({{(cckb_pkg::COORD_W-cckb_pkg::SPAN_W){1'b0}}, scan_row_ff});
      stat.key    = key_ff;
   end

endmodule

FILE: rtl/core/clipped_color_key_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped color key blitter
// Frame store with fill, clipped color-keyed sprite drawing and pixel reads.
// ----------------------------------------------------------------------------
// Start and sprite pixel beats: ST_EXEC waits for a free output register, then registers the result.
// Read beats: ST_EXEC issues the frame RAM read and ST_READ registers the read data as the result.
// Fill beats: one RAM write per cycle over the frame, then the result once the output is free.
// Only one item is in flight; the output register lets the next item start while a
// result waits. After reset every frame entry is cleared to zero with req_ready low.
// ----------------------------------------------------------------------------
`include "clipped_color_key_blitter_assert.svh"

module clipped_color_key_blitter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic signed [cckb_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [cckb_pkg::POS_W-1:0]   req_pos_y,
   input  logic [cckb_pkg::SPAN_W-1:0]         req_sprite_width,
   input  logic [cckb_pkg::SPAN_W-1:0]         req_sprite_height,
   input  logic [cckb_pkg::PIXEL_W-1:0]        req_pixel_color,
   input  logic signed [cckb_pkg::KEY_W-1:0]   req_key_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cckb_pkg::PIXEL_W-1:0]        rsp_read_pixel,
   output logic                                rsp_pixel_written,
   output logic                                rsp_sprite_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_color_depth
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_READ
   } state_type;

   state_type                         state_ff, state_in;
   logic [cckb_pkg::ADDR_W-1:0]       cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cckb_pkg::PIXEL_W-1:0]      rsp_pixel_ff, rsp_pixel_in;
   logic                              rsp_written_ff, rsp_written_in;
   logic                              rsp_done_ff, rsp_done_in;
   logic                              rd_hit_ff, rd_hit_in;
   logic                              color_depth_ff;

   cckb_pkg::cmd_type                 cmd_ff;
   logic signed [cckb_pkg::POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [cckb_pkg::SPAN_W-1:0]       width_ff, height_ff;
   logic [cckb_pkg::PIXEL_W-1:0]      color_ff;
   logic [cckb_pkg::KEY_W-1:0]        key_ff;

   logic                              mem_we, mem_re;
   logic [cckb_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [cckb_pkg::PIXEL_W-1:0]      mem_wdata, mem_rdata;

   cckb_pkg::scan_ctrl_type           scan_ctrl;
   cckb_pkg::scan_stat_type           scan_stat;

   logic                              out_free;
   logic [cckb_pkg::PIXEL_W-1:0]      narrow_color, rd_masked;
   logic signed [cckb_pkg::COORD_W-1:0] rd_col, rd_row;
   logic                              rd_on, pix_on, key_hit, pix_store;
   logic                              req_beat, pix_beat;

   cckb_ram #(
      .WIDTH (cckb_pkg::PIXEL_W),
      .DEPTH (cckb_pkg::STORE_DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   cckb_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (scan_ctrl),
      .pos_x  (pos_x_ff),
      .pos_y  (pos_y_ff),
      .span_w (width_ff),
      .span_h (height_ff),
      .key    (key_ff),
      .stat   (scan_stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;
   assign pix_beat  = rsp_valid && rsp_pixel_written;

   // In 8-bit depth only the low byte is stored, compared and read back.
   assign narrow_color = color_depth_ff ? color_ff
                       : {{(cckb_pkg::PIXEL_W-cckb_pkg::NARROW_W){1'b0}},
                          color_ff[cckb_pkg::NARROW_W-1:0]};
   assign rd_masked    = color_depth_ff ? mem_rdata
                       : {{(cckb_pkg::PIXEL_W-cckb_pkg::NARROW_W){1'b0}},
                          mem_rdata[cckb_pkg::NARROW_W-1:0]};

   assign rd_col    = cckb_pkg::widen_pos(pos_x_ff);
   assign rd_row    = cckb_pkg::widen_pos(pos_y_ff);
   assign rd_on     = cckb_pkg::on_screen(rd_col, rd_row);
   assign pix_on    = cckb_pkg::on_screen(scan_stat.col, scan_stat.row);
   // A negative key never equals a zero-extended color, so minus one disables keying.
   assign key_hit   = ({1'b0, narrow_color} == scan_stat.key);
   assign pix_store = scan_stat.active && pix_on && !key_hit;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in   = rsp_pixel_ff;
      rsp_written_in = rsp_written_ff;
      rsp_done_in    = rsp_done_ff;
      rd_hit_in      = rd_hit_ff;
      mem_we         = 1'b0;
      mem_waddr      = cnt_ff;
      mem_wdata      = narrow_color;
      mem_re         = 1'b0;
      mem_raddr      = cckb_pkg::store_addr(rd_col, rd_row);
      scan_ctrl      = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (cnt_ff == cckb_pkg::STORE_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               cckb_pkg::CMD_FILL: begin
                  cnt_in   = '0;
                  state_in = ST_FILL;
               end
               cckb_pkg::CMD_START: begin
                  if (out_free) begin
                     scan_ctrl.start = 1'b1;
                     rsp_valid_in    = 1'b1;
                     rsp_pixel_in    = '0;
                     rsp_written_in  = 1'b0;
                     rsp_done_in     = (width_ff == '0) || (height_ff == '0);
                     state_in        = ST_IDLE;
                  end
               end
               cckb_pkg::CMD_PIXEL: begin
                  if (out_free) begin
                     scan_ctrl.step = 1'b1;
                     mem_we         = pix_store;
                     mem_waddr      = cckb_pkg::store_addr(scan_stat.col, scan_stat.row);
                     rsp_valid_in   = 1'b1;
                     rsp_pixel_in   = '0;
                     rsp_written_in = pix_store;
                     rsp_done_in    = scan_stat.active && scan_stat.last;
                     state_in       = ST_IDLE;
                  end
               end
               cckb_pkg::CMD_READ: begin
                  mem_re    = rd_on;
                  rd_hit_in = rd_on;
                  state_in  = ST_READ;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (cnt_ff == cckb_pkg::STORE_LAST) begin
               // The last entry is simply written again while the result waits.
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_pixel_in   = '0;
                  rsp_written_in = 1'b0;
                  rsp_done_in    = 1'b0;
                  cnt_in         = '0;
                  state_in       = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_READ: begin
            // Read data stays put because no other read is issued meanwhile.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pixel_in   = rd_hit_ff ? rd_masked : '0;
               rsp_written_in = 1'b0;
               rsp_done_in    = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_pixel_ff   <= '0;
         rsp_written_ff <= 1'b0;
         rsp_done_ff    <= 1'b0;
         rd_hit_ff      <= 1'b0;
         color_depth_ff <= 1'b1;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_pixel_ff   <= rsp_pixel_in;
         rsp_written_ff <= rsp_written_in;
         rsp_done_ff    <= rsp_done_in;
         rd_hit_ff      <= rd_hit_in;
         if (csr_valid) begin
            color_depth_ff <= csr_color_depth;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff    <= cckb_pkg::cmd_type'(req_cmd);
         pos_x_ff  <= req_pos_x;
         pos_y_ff  <= req_pos_y;
         width_ff  <= req_sprite_width;
         height_ff <= req_sprite_height;
         color_ff  <= req_pixel_color;
         key_ff    <= req_key_value;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_pixel    = rsp_pixel_ff;
   assign rsp_pixel_written = rsp_written_ff;
   assign rsp_sprite_done   = rsp_done_ff;

   `CCKB_ASSERT_NEXT(a_single_item, clock, reset, req_beat, !req_ready, "beat taken while busy")
   `CCKB_ASSERT_SAME(a_idle_no_write, clock, reset, req_ready, !mem_we, "write while idle")
   `CCKB_ASSERT_SAME(a_write_no_read, clock, reset, pix_beat, ~|rsp_read_pixel, "data on write")

endmodule
